[rtl/bimthin_pkg.sv]
// Shared types and constants for the binary image thinning block.
package bimthin_pkg;

    // Payload field widths
    localparam int KIND_W    = 2;
    localparam int IN_ROW_W  = 7;
    localparam int IN_COL_W  = 7;
    localparam int PIX_W     = 8;
    localparam int CNT_W     = 14;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = 8'd128;
    localparam logic [CFG_W-1:0]     MIN_DIM          = 8'd3;

    // Pixel coding and thinning rule limits
    localparam logic [PIX_W-1:0] FG_BYTE   = 8'd255;
    localparam logic [PIX_W-1:0] BG_BYTE   = 8'd0;
    localparam logic [3:0]       MIN_NBRS  = 4'd2;
    localparam logic [3:0]       MAX_NBRS  = 4'd6;
    localparam logic [CNT_W-1:0] COUNT_MAX = 14'd16383;
    localparam logic [1:0]       EMPTY_STOP = 2'd2;

    // 3x3 ring around the pixel under test
    typedef struct packed {
        logic n;
        logic ne;
        logic e;
        logic se;
        logic s;
        logic sw;
        logic w;
        logic nw;
    } nbr_t;

endpackage

[rtl/bimthin_if.sv]
// Valid/ready channel interfaces for pixel items and results.
interface bimthin_item_if;
    logic                             valid;
    logic                             ready;
    logic [bimthin_pkg::KIND_W-1:0]   kind;
    logic [bimthin_pkg::IN_ROW_W-1:0] row;
    logic [bimthin_pkg::IN_COL_W-1:0] col;
    logic [bimthin_pkg::PIX_W-1:0]    pixel_value;

    modport source (output valid, kind, row, col, pixel_value, input ready);
    modport sink   (input valid, kind, row, col, pixel_value, output ready);
endinterface

interface bimthin_result_if;
    logic                          valid;
    logic                          ready;
    logic [bimthin_pkg::PIX_W-1:0] pixel_out;
    logic [bimthin_pkg::CNT_W-1:0] subiteration_count;

    modport source (output valid, pixel_out, subiteration_count, input ready);
    modport sink   (input valid, pixel_out, subiteration_count, output ready);
endinterface

[rtl/bimthin_eval.sv]
// Zhang-Suen deletion test for one foreground pixel's neighborhood.
module bimthin_eval (
    input  bimthin_pkg::nbr_t nbrs,
    input  logic              odd_phase,
    output logic              deletable
);

    logic [7:0] ring;
    logic [7:0] rise_vec;
    logic [3:0] nbr_cnt;
    logic       cnt_ok;
    logic       phase_ok;

    // ring[k] walks N, NE, E, SE, S, SW, W, NW
    assign ring = {nbrs.nw, nbrs.w, nbrs.sw, nbrs.s, nbrs.se, nbrs.e, nbrs.ne, nbrs.n};

    // 0-to-1 transitions around the closed ring
    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            rise_vec[k] = !ring[k] && ring[(k + 1) % 8];
        end
    end

    assign nbr_cnt = 4'($countones(ring));
    assign cnt_ok  = (nbr_cnt >= bimthin_pkg::MIN_NBRS) && (nbr_cnt <= bimthin_pkg::MAX_NBRS);

    // Phase product tests
    always_comb
    begin
        if (odd_phase)
        begin
            phase_ok = !(nbrs.n & nbrs.e & nbrs.s) && !(nbrs.e & nbrs.s & nbrs.w);
        end
        else
        begin
            phase_ok = !(nbrs.n & nbrs.e & nbrs.w) && !(nbrs.n & nbrs.s & nbrs.w);
        end
    end

    assign deletable = cnt_ok && $onehot(rise_vec) && phase_ok;

endmodule

[rtl/binary_image_thinning.sv]
// A load writes one pixel bit into the row memory; a read fetches the addressed row and offers
// its result once the result register is free. A run repeats sub-iterations on a W x H image:
// one shared neighborhood test evaluates one interior pixel per cycle from three row
// registers, and each image row costs one fetch and one write-back on the row memory.
// The input is not ready while a read or run is in progress.
// Reset clears control state and sets both dimensions to 128; image memory is not cleared.
module binary_image_thinning #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bimthin_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bimthin_pkg::CFG_W-1:0]       cfg_data,
    bimthin_item_if.sink                        item,
    bimthin_result_if.source                    result
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WD_W  = $clog2(MAX_WIDTH + 1);
    localparam int HT_W  = $clog2(MAX_HEIGHT + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD0,
        S_LOAD1,
        S_LOAD2,
        S_FETCH,
        S_COL,
        S_WB,
        S_SUBEND,
        S_DONE
    } state_t;

    state_t                           state_reg;
    logic [bimthin_pkg::CFG_W-1:0]    width_reg;
    logic [bimthin_pkg::CFG_W-1:0]    height_reg;
    logic [ROW_W-1:0]                 row_reg;
    logic [COL_W-1:0]                 col_reg;
    logic [MAX_WIDTH-1:0]             top_reg;
    logic [MAX_WIDTH-1:0]             mid_reg;
    logic [MAX_WIDTH-1:0]             bot_reg;
    logic [MAX_WIDTH-1:0]             marks_reg;
    logic                             any_mark_reg;
    logic                             odd_phase_reg;
    logic [1:0]                       empty_reg;
    logic [bimthin_pkg::CNT_W-1:0]    count_reg;
    logic [COL_W-1:0]                 rd_col_reg;
    logic                             rd_inside_reg;
    logic                             out_valid_reg;
    logic [bimthin_pkg::PIX_W-1:0]    out_pixel_reg;
    logic [bimthin_pkg::CNT_W-1:0]    out_count_reg;

    // Image store: one row per word
    logic [MAX_WIDTH-1:0]             mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0]             mem_q;

    logic                             rd_en;
    logic [ROW_W-1:0]                 rd_addr;
    logic                             row_wr_en;
    logic                             bit_wr_en;
    logic [ROW_W-1:0]                 wr_addr;
    logic [COL_W-1:0]                 wr_col;
    logic                             wr_bit;

    logic                             in_xfer;
    logic                             in_inside;
    logic                             out_free;
    logic [WD_W-1:0]                  w_use;
    logic [HT_W-1:0]                  h_use;
    logic [COL_W-1:0]                 last_col;
    logic [ROW_W-1:0]                 last_row;
    logic [COL_W-1:0]                 col_m1;
    logic [COL_W-1:0]                 col_p1;
    bimthin_pkg::nbr_t                win;
    logic                             deletable;
    logic                             del_hit;
    logic [1:0]                       empty_next;

    assign item.ready = (state_reg == S_IDLE);
    assign in_xfer    = item.valid && item.ready;
    assign in_inside  = (32'(item.row) < MAX_HEIGHT) && (32'(item.col) < MAX_WIDTH);
    assign out_free   = !out_valid_reg || result.ready;

    assign result.valid              = out_valid_reg;
    assign result.pixel_out          = out_pixel_reg;
    assign result.subiteration_count = out_count_reg;

    // Dimensions in use, clamped to the legal range
    always_comb
    begin
        if (width_reg < bimthin_pkg::MIN_DIM)
        begin
            w_use = WD_W'(bimthin_pkg::MIN_DIM);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_use = WD_W'(MAX_WIDTH);
        end
        else
        begin
            w_use = WD_W'(width_reg);
        end
        if (height_reg < bimthin_pkg::MIN_DIM)
        begin
            h_use = HT_W'(bimthin_pkg::MIN_DIM);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_use = HT_W'(MAX_HEIGHT);
        end
        else
        begin
            h_use = HT_W'(height_reg);
        end
    end

    assign last_col = COL_W'(w_use - WD_W'(2));
    assign last_row = ROW_W'(h_use - HT_W'(2));

    // 3x3 window around the column under test
    assign col_m1 = col_reg - COL_W'(1);
    assign col_p1 = col_reg + COL_W'(1);

    always_comb
    begin
        win.n  = top_reg[col_reg];
        win.ne = top_reg[col_p1];
        win.e  = mid_reg[col_p1];
        win.se = bot_reg[col_p1];
        win.s  = bot_reg[col_reg];
        win.sw = bot_reg[col_m1];
        win.w  = mid_reg[col_m1];
        win.nw = top_reg[col_m1];
    end

    bimthin_eval u_eval (
        .nbrs      (win),
        .odd_phase (odd_phase_reg),
        .deletable (deletable)
    );

    assign del_hit    = mid_reg[col_reg] && deletable;
    assign empty_next = any_mark_reg ? 2'd0 : empty_reg + 2'd1;

    // Memory port control
    always_comb
    begin
        rd_en     = 1'b0;
        rd_addr   = ROW_W'(item.row);
        row_wr_en = 1'b0;
        bit_wr_en = 1'b0;
        wr_addr   = ROW_W'(item.row);
        wr_col    = COL_W'(item.col);
        wr_bit    = (item.pixel_value == bimthin_pkg::FG_BYTE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && in_inside)
                begin
                    rd_en     = (item.kind == bimthin_pkg::KIND_READ);
                    bit_wr_en = (item.kind == bimthin_pkg::KIND_LOAD);
                end
            end
            S_LOAD0:
            begin
                rd_en   = 1'b1;
                rd_addr = ROW_W'(0);
            end
            S_LOAD1:
            begin
                rd_en   = 1'b1;
                rd_addr = ROW_W'(1);
            end
            S_LOAD2:
            begin
                rd_en   = 1'b1;
                rd_addr = ROW_W'(2);
            end
            S_WB:
            begin
                row_wr_en = 1'b1;
                wr_addr   = row_reg;
                rd_en     = (row_reg != last_row);
                rd_addr   = row_reg + ROW_W'(2);
            end
            default:
            begin
            end
        endcase
    end

    // Image row memory with row write and single-bit load write
    always_ff @(posedge clk)
    begin
        if (row_wr_en)
        begin
            mem[wr_addr] <= mid_reg & ~marks_reg;
        end
        else if (bit_wr_en)
        begin
            mem[wr_addr][wr_col] <= wr_bit;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bimthin_pkg::CFG_DIM_RESET;
            height_reg <= bimthin_pkg::CFG_DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bimthin_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                bimthin_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Sequencer, scan registers and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            top_reg       <= '0;
            mid_reg       <= '0;
            bot_reg       <= '0;
            marks_reg     <= '0;
            any_mark_reg  <= 1'b0;
            odd_phase_reg <= 1'b1;
            empty_reg     <= 2'd0;
            count_reg     <= '0;
            rd_col_reg    <= '0;
            rd_inside_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            out_pixel_reg <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        case (item.kind)
                            bimthin_pkg::KIND_RUN:
                            begin
                                odd_phase_reg <= 1'b1;
                                empty_reg     <= 2'd0;
                                count_reg     <= '0;
                                any_mark_reg  <= 1'b0;
                                state_reg     <= S_LOAD0;
                            end
                            bimthin_pkg::KIND_READ:
                            begin
                                rd_col_reg    <= COL_W'(item.col);
                                rd_inside_reg <= in_inside;
                                state_reg     <= S_READ;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pixel_reg <= (rd_inside_reg && mem_q[rd_col_reg]) ?
                                         bimthin_pkg::FG_BYTE : bimthin_pkg::BG_BYTE;
                        out_count_reg <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                S_LOAD0:
                begin
                    state_reg <= S_LOAD1;
                end
                S_LOAD1:
                begin
                    top_reg   <= mem_q;
                    state_reg <= S_LOAD2;
                end
                S_LOAD2:
                begin
                    mid_reg   <= mem_q;
                    row_reg   <= ROW_W'(1);
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    bot_reg   <= mem_q;
                    col_reg   <= COL_W'(1);
                    marks_reg <= '0;
                    state_reg <= S_COL;
                end
                S_COL:
                begin
                    marks_reg[col_reg] <= del_hit;
                    any_mark_reg       <= any_mark_reg | del_hit;
                    if (col_reg == last_col)
                    begin
                        state_reg <= S_WB;
                    end
                    else
                    begin
                        col_reg <= col_p1;
                    end
                end
                S_WB:
                begin
                    // Window slides down on the original rows
                    top_reg <= mid_reg;
                    mid_reg <= bot_reg;
                    if (row_reg == last_row)
                    begin
                        state_reg <= S_SUBEND;
                    end
                    else
                    begin
                        row_reg   <= row_reg + ROW_W'(1);
                        state_reg <= S_FETCH;
                    end
                end
                S_SUBEND:
                begin
                    if (count_reg != bimthin_pkg::COUNT_MAX)
                    begin
                        count_reg <= count_reg + bimthin_pkg::CNT_W'(1);
                    end
                    empty_reg     <= empty_next;
                    odd_phase_reg <= !odd_phase_reg;
                    any_mark_reg  <= 1'b0;
                    state_reg     <= (empty_next == bimthin_pkg::EMPTY_STOP) ? S_DONE : S_LOAD0;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pixel_reg <= bimthin_pkg::BG_BYTE;
                        out_count_reg <= count_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    // Column scan stays inside the interior
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COL |-> col_reg != '0 && col_reg <= last_col)
        else $error("column scan left the image interior");

    // Border column is never marked
    a_border_mark: assert property (@(posedge clk) disable iff (!rst_n)
        !marks_reg[0])
        else $error("border pixel marked for deletion");

    // A result carries either a pixel or a count
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.pixel_out == bimthin_pkg::BG_BYTE ||
                         result.subiteration_count == '0)
        else $error("result mixes pixel and count");

    // A run needs at least two sub-iterations to stop
    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE |-> count_reg >= bimthin_pkg::CNT_W'(2))
        else $error("run finished too early");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the binary image thinning block.
`timescale 1ns / 100ps

module testbench;

    localparam int IMG_W         = 128;
    localparam int IMG_H         = 128;
    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 20;
    localparam int TAIL_OPS      = 150;
    localparam int RUN_LIMIT_NS  = 50_000_000;

    // Item kind that the block ignores
    localparam logic [bimthin_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

    // Source and sink idle behavior
    localparam int STALL_NONE  = 0;
    localparam int STALL_LIGHT = 1;
    localparam int STALL_HEAVY = 2;

    // One pending operation: a register write or an item transfer
    typedef struct {
        bit                                 is_cfg;
        logic [bimthin_pkg::CFG_IDX_W-1:0]  reg_idx;
        logic [bimthin_pkg::CFG_W-1:0]      reg_val;
        logic [bimthin_pkg::KIND_W-1:0]     kind;
        logic [bimthin_pkg::IN_ROW_W-1:0]   row;
        logic [bimthin_pkg::IN_COL_W-1:0]   col;
        logic [bimthin_pkg::PIX_W-1:0]      pixel_value;
    } image_op_t;

    typedef struct packed {
        logic [bimthin_pkg::PIX_W-1:0] pixel_out;
        logic [bimthin_pkg::CNT_W-1:0] subiteration_count;
    } answer_t;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [bimthin_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bimthin_pkg::CFG_W-1:0]     cfg_data;

    bimthin_item_if   item_ch ();
    bimthin_result_if result_ch ();

    binary_image_thinning #(
        .MAX_WIDTH  (IMG_W),
        .MAX_HEIGHT (IMG_H)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_ch),
        .result    (result_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Operation queue and expected answers
    image_op_t image_ops[$];
    answer_t   due_answers[$];
    int        fail_count = 0;

    // Predictor state
    bit                            pix_store [0:IMG_H-1][0:IMG_W-1];
    bit                            strike    [0:IMG_H-1][0:IMG_W-1];
    logic [bimthin_pkg::CFG_W-1:0] width_reg  = bimthin_pkg::CFG_DIM_RESET;
    logic [bimthin_pkg::CFG_W-1:0] height_reg = bimthin_pkg::CFG_DIM_RESET;

    // Generator view: which pixels hold a defined value, and the image in use
    bit gen_written [0:IMG_H-1][0:IMG_W-1];
    int gen_w = IMG_W;
    int gen_h = IMG_H;

    // Driver state
    bit item_taken = 1'b0;
    int settle     = 0;
    int src_gap    = 0;
    int snk_gap    = 0;
    int src_mode   = STALL_LIGHT;
    int snk_mode   = STALL_LIGHT;

    // Dimension register to dimension in use
    function automatic int fit_dim(logic [bimthin_pkg::CFG_W-1:0] v, int top);
        if (v < bimthin_pkg::MIN_DIM)
            return bimthin_pkg::MIN_DIM;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic bit stall_now(int mode);
        case (mode)
            STALL_LIGHT: return $urandom_range(0, 15) == 0;
            STALL_HEAVY: return $urandom_range(0, 2) == 0;
            default:     return 1'b0;
        endcase
    endfunction

    // Deletion test for one interior pixel in the current phase
    function automatic bit removable(int r, int c, bit odd_rule);
        bimthin_pkg::nbr_t nb;
        logic [0:7]        ring;
        int                fg_cnt;
        int                rises;
        int                k;
        nb.n  = pix_store[r-1][c];
        nb.ne = pix_store[r-1][c+1];
        nb.e  = pix_store[r][c+1];
        nb.se = pix_store[r+1][c+1];
        nb.s  = pix_store[r+1][c];
        nb.sw = pix_store[r+1][c-1];
        nb.w  = pix_store[r][c-1];
        nb.nw = pix_store[r-1][c-1];
        ring = nb;
        fg_cnt = $countones(ring);
        rises = 0;
        for (k = 0; k < 8; k++)
            if (!ring[k] && ring[(k + 1) % 8])
                rises++;
        if (fg_cnt < bimthin_pkg::MIN_NBRS || fg_cnt > bimthin_pkg::MAX_NBRS || rises != 1)
            return 1'b0;
        if (odd_rule)
            return !(nb.n & nb.e & nb.s) && !(nb.e & nb.s & nb.w);
        return !(nb.n & nb.e & nb.w) && !(nb.n & nb.s & nb.w);
    endfunction

    // Full thinning run; stops after two sub-iterations in a row that remove nothing
    task automatic thin_image(output logic [bimthin_pkg::CNT_W-1:0] sub_cnt);
        int         cols;
        int         rows;
        int         r;
        int         c;
        int         marked;
        bit         odd_rule;
        logic [1:0] quiet_subs;
        cols = fit_dim(width_reg, IMG_W);
        rows = fit_dim(height_reg, IMG_H);
        odd_rule = 1'b1;
        quiet_subs = '0;
        sub_cnt = '0;
        while (quiet_subs < bimthin_pkg::EMPTY_STOP)
        begin
            marked = 0;
            for (r = 1; r + 1 < rows; r++)
                for (c = 1; c + 1 < cols; c++)
                    if (pix_store[r][c] && removable(r, c, odd_rule))
                    begin
                        strike[r][c] = 1'b1;
                        marked++;
                    end
            for (r = 1; r + 1 < rows; r++)
                for (c = 1; c + 1 < cols; c++)
                    if (strike[r][c])
                    begin
                        pix_store[r][c] = 1'b0;
                        strike[r][c] = 1'b0;
                    end
            if (sub_cnt != bimthin_pkg::COUNT_MAX)
                sub_cnt++;
            quiet_subs = (marked != 0) ? 2'd0 : quiet_subs + 2'd1;
            odd_rule = !odd_rule;
        end
    endtask

    // ---------------- stimulus building ----------------

    task automatic push_cfg(logic [bimthin_pkg::CFG_IDX_W-1:0] idx,
                            logic [bimthin_pkg::CFG_W-1:0] val);
        image_op_t op;
        op.is_cfg = 1'b1;
        op.reg_idx = idx;
        op.reg_val = val;
        op.kind = bimthin_pkg::KIND_LOAD;
        op.row = '0;
        op.col = '0;
        op.pixel_value = '0;
        image_ops.insert(image_ops.size(), op);
        if (idx == bimthin_pkg::CFG_IMAGE_WIDTH)
            gen_w = fit_dim(val, IMG_W);
        else
            gen_h = fit_dim(val, IMG_H);
    endtask

    task automatic push_item(logic [bimthin_pkg::KIND_W-1:0] kind, int row, int col, int val);
        image_op_t op;
        op.is_cfg = 1'b0;
        op.reg_idx = '0;
        op.reg_val = '0;
        op.kind = kind;
        op.row = bimthin_pkg::IN_ROW_W'(row);
        op.col = bimthin_pkg::IN_COL_W'(col);
        op.pixel_value = bimthin_pkg::PIX_W'(val);
        image_ops.insert(image_ops.size(), op);
        if (kind == bimthin_pkg::KIND_LOAD)
            gen_written[row][col] = 1'b1;
    endtask

    // Read a defined pixel: anywhere in the store, or inside the image in use
    task automatic push_read(bit anywhere);
        int r;
        int c;
        int rr;
        int cc;
        int t;
        bit found;
        r = $urandom_range(0, gen_h - 1);
        c = $urandom_range(0, gen_w - 1);
        found = 1'b0;
        for (t = 0; t < 8 && anywhere && !found; t++)
        begin
            rr = $urandom_range(0, IMG_H - 1);
            cc = $urandom_range(0, IMG_W - 1);
            if (gen_written[rr][cc])
            begin
                r = rr;
                c = cc;
                found = 1'b1;
            end
        end
        push_item(bimthin_pkg::KIND_READ, r, c, $urandom_range(0, 255));
    endtask

    // Fill the whole image in use: a few solid blocks over background, plus speckle
    task automatic load_region(int cap);
        int nrect;
        int top   [3];
        int left  [3];
        int hgt   [3];
        int wid   [3];
        int k;
        int r;
        int c;
        bit fg;
        nrect = $urandom_range(1, 3);
        for (k = 0; k < 3; k++)
        begin
            hgt[k]  = $urandom_range(1, (cap < gen_h) ? cap : gen_h);
            wid[k]  = $urandom_range(1, (cap < gen_w) ? cap : gen_w);
            top[k]  = $urandom_range(0, gen_h - hgt[k]);
            left[k] = $urandom_range(0, gen_w - wid[k]);
        end
        for (r = 0; r < gen_h; r++)
            for (c = 0; c < gen_w; c++)
            begin
                fg = 1'b0;
                for (k = 0; k < nrect; k++)
                    if (r >= top[k] && r < top[k] + hgt[k] &&
                        c >= left[k] && c < left[k] + wid[k])
                        fg = 1'b1;
                if ($urandom_range(0, 15) == 0)
                    fg = !fg;
                push_item(bimthin_pkg::KIND_LOAD, r, c,
                          fg ? bimthin_pkg::FG_BYTE :
                          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 254) :
                          bimthin_pkg::BG_BYTE);
            end
    endtask

    // Mixed traffic on a loaded image; ignored items are not counted
    task automatic random_mix(int n);
        int done;
        int sel;
        done = 0;
        while (done < n)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                push_item(bimthin_pkg::KIND_LOAD, $urandom_range(0, gen_h - 1),
                          $urandom_range(0, gen_w - 1),
                          ($urandom_range(0, 2) != 0) ? bimthin_pkg::FG_BYTE :
                          $urandom_range(0, 255));
            else if (sel < 55)
                push_item(bimthin_pkg::KIND_LOAD, $urandom_range(0, IMG_H - 1),
                          $urandom_range(0, IMG_W - 1),
                          ($urandom_range(0, 1) != 0) ? bimthin_pkg::FG_BYTE :
                          $urandom_range(0, 255));
            else if (sel < 82)
                push_read(1'($urandom_range(0, 1)));
            else if (sel < 95)
                push_item(bimthin_pkg::KIND_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 255));
            else
                push_item(KIND_SPARE, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 255));
            if (sel < 95)
                done++;
        end
    endtask

    // One setting: configure, load, thin, sample, disturb, thin, sample
    task automatic thin_phase(logic [bimthin_pkg::CFG_W-1:0] wval,
                              logic [bimthin_pkg::CFG_W-1:0] hval,
                              int cap, int mix_len, int reads);
        int i;
        if ($urandom_range(0, 1) != 0)
        begin
            push_cfg(bimthin_pkg::CFG_IMAGE_WIDTH, wval);
            push_cfg(bimthin_pkg::CFG_IMAGE_HEIGHT, hval);
        end
        else
        begin
            push_cfg(bimthin_pkg::CFG_IMAGE_HEIGHT, hval);
            push_cfg(bimthin_pkg::CFG_IMAGE_WIDTH, wval);
        end
        load_region(cap);
        push_item(bimthin_pkg::KIND_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 255));
        for (i = 0; i < reads; i++)
            push_read(1'b0);
        random_mix(mix_len);
        push_item(bimthin_pkg::KIND_RUN, $urandom_range(0, 127), $urandom_range(0, 127),
                  $urandom_range(0, 255));
        for (i = 0; i < reads; i++)
            push_read(1'b0);
    endtask

    // ---------------- item driver ----------------
    always @(negedge clk)
    begin : item_driver
        bit        drive_valid;
        bit        drive_we;
        image_op_t head;
        drive_valid = 1'b0;
        drive_we = 1'b0;
        if (rst_n)
        begin
            if ($urandom_range(0, 127) == 0)
                src_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            if (image_ops.size() != 0)
                head = image_ops[0];
            if (item_ch.valid && !item_taken)
                drive_valid = 1'b1;
            else if (image_ops.size() != 0 && head.is_cfg)
            begin
                // register writes only once the block has gone quiet
                settle = (due_answers.size() == 0) ? settle + 1 : 0;
                if (settle > SETTLE_CYCLES)
                begin
                    drive_we = 1'b1;
                    settle = 0;
                    cfg_index <= head.reg_idx;
                    cfg_data <= head.reg_val;
                end
            end
            else if (src_gap != 0)
                src_gap--;
            else if (image_ops.size() != 0)
            begin
                if (image_ops.size() >= TAIL_OPS && stall_now(src_mode))
                    src_gap = $urandom_range(0, 14);
                else
                begin
                    drive_valid = 1'b1;
                    item_ch.kind <= head.kind;
                    item_ch.row <= head.row;
                    item_ch.col <= head.col;
                    item_ch.pixel_value <= head.pixel_value;
                end
            end
            item_taken = 1'b0;
            item_ch.valid <= drive_valid;
            cfg_we <= drive_we;
        end
    end

    // ---------------- result ready driver ----------------
    always @(negedge clk)
    begin : result_driver
        bit accept;
        accept = 1'b0;
        if (rst_n)
        begin
            if ($urandom_range(0, 127) == 0)
                snk_mode = $urandom_range(STALL_NONE, STALL_HEAVY);
            if (snk_gap != 0)
                snk_gap--;
            else if (image_ops.size() >= TAIL_OPS && stall_now(snk_mode))
                snk_gap = $urandom_range(0, 14);
            else
                accept = 1'b1;
            result_ch.ready <= accept;
        end
    end

    // ---------------- monitor and prediction ----------------
    always @(posedge clk)
    begin : monitor
        answer_t                       want;
        logic [bimthin_pkg::CNT_W-1:0] sub_cnt;
        if (rst_n)
        begin
            // result transfer: check against the oldest expectation
            if (result_ch.valid && result_ch.ready)
            begin
                if (due_answers.size() == 0)
                begin
                    $error("result with nothing expected: pixel_out %0d, subiteration_count %0d",
                           result_ch.pixel_out, result_ch.subiteration_count);
                    fail_count++;
                end
                else
                begin
                    want = due_answers.pop_front();
                    if (result_ch.pixel_out !== want.pixel_out)
                    begin
                        $error("pixel_out: expected %0d, got %0d",
                               want.pixel_out, result_ch.pixel_out);
                        fail_count++;
                    end
                    if (result_ch.subiteration_count !== want.subiteration_count)
                    begin
                        $error("subiteration_count: expected %0d, got %0d",
                               want.subiteration_count, result_ch.subiteration_count);
                        fail_count++;
                    end
                end
            end

            // register write
            if (cfg_we)
            begin
                if (cfg_index == bimthin_pkg::CFG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else
                    height_reg = cfg_data;
                void'(image_ops.pop_front());
            end

            // item transfer: update the image model and queue the answer
            if (item_ch.valid && item_ch.ready)
            begin
                case (item_ch.kind)
                    bimthin_pkg::KIND_LOAD:
                        pix_store[item_ch.row][item_ch.col] =
                            (item_ch.pixel_value == bimthin_pkg::FG_BYTE);
                    bimthin_pkg::KIND_RUN:
                    begin
                        thin_image(sub_cnt);
                        want.pixel_out = bimthin_pkg::BG_BYTE;
                        want.subiteration_count = sub_cnt;
                        due_answers.insert(due_answers.size(), want);
                    end
                    bimthin_pkg::KIND_READ:
                    begin
                        want.pixel_out = pix_store[item_ch.row][item_ch.col] ?
                                         bimthin_pkg::FG_BYTE : bimthin_pkg::BG_BYTE;
                        want.subiteration_count = '0;
                        due_answers.insert(due_answers.size(), want);
                    end
                    default: ;
                endcase
                void'(image_ops.pop_front());
                item_taken = 1'b1;
            end
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial
    begin : stimulus
        int p;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.kind = bimthin_pkg::KIND_LOAD;
        item_ch.row = '0;
        item_ch.col = '0;
        item_ch.pixel_value = '0;
        result_ch.ready = 1'b0;

        // Directed: smallest image, north-west corner of a 2x2 block gets removed
        push_cfg(bimthin_pkg::CFG_IMAGE_WIDTH, bimthin_pkg::MIN_DIM);
        push_cfg(bimthin_pkg::CFG_IMAGE_HEIGHT, bimthin_pkg::MIN_DIM);
        push_item(bimthin_pkg::KIND_LOAD, 0, 0, 0);
        push_item(bimthin_pkg::KIND_LOAD, 0, 1, 254);
        push_item(bimthin_pkg::KIND_LOAD, 0, 2, 1);
        push_item(bimthin_pkg::KIND_LOAD, 1, 0, 128);
        push_item(bimthin_pkg::KIND_LOAD, 1, 1, bimthin_pkg::FG_BYTE);
        push_item(bimthin_pkg::KIND_LOAD, 1, 2, bimthin_pkg::FG_BYTE);
        push_item(bimthin_pkg::KIND_LOAD, 2, 0, 127);
        push_item(bimthin_pkg::KIND_LOAD, 2, 1, bimthin_pkg::FG_BYTE);
        push_item(bimthin_pkg::KIND_LOAD, 2, 2, bimthin_pkg::FG_BYTE);
        push_item(bimthin_pkg::KIND_RUN, 0, 0, 0);
        push_item(bimthin_pkg::KIND_READ, 1, 1, 0);
        push_item(bimthin_pkg::KIND_READ, 1, 2, 0);
        push_item(bimthin_pkg::KIND_READ, 2, 2, 0);
        // already thin: stops after two empty sub-iterations
        push_item(bimthin_pkg::KIND_RUN, 127, 127, 255);
        // far corners of the store, outside the image in use
        push_item(bimthin_pkg::KIND_LOAD, 127, 127, bimthin_pkg::FG_BYTE);
        push_item(bimthin_pkg::KIND_LOAD, 127, 0, 64);
        push_item(bimthin_pkg::KIND_READ, 127, 127, 255);
        push_item(bimthin_pkg::KIND_READ, 127, 0, 0);
        push_item(KIND_SPARE, 127, 127, 255);

        // Random phases, mostly small images, dimension extremes in between
        for (p = 0; p < 2; p++)
            thin_phase(8'($urandom_range(3, 14)), 8'($urandom_range(3, 14)), 14, 60, 12);
        thin_phase(8'd2, 8'd255, 14, 40, 12);
        thin_phase(8'd129, 8'd0, 14, 40, 12);
        for (p = 0; p < 2; p++)
            thin_phase(8'($urandom_range(3, 14)), 8'($urandom_range(3, 14)), 14, 60, 12);
        thin_phase(8'd1, bimthin_pkg::MIN_DIM, 3, 30, 9);

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wait for every transfer and answer, then let the block drain
        while (image_ops.size() != 0 || due_answers.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && due_answers.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard limit on run length
    initial
    begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[binary_image_thinning.f]
rtl/bimthin_pkg.sv
rtl/bimthin_if.sv
rtl/bimthin_eval.sv
rtl/binary_image_thinning.sv
tb/testbench.sv
